// File: sv/lcg_ranged_random_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ranged random generator
// Shared property forms for the checker on the top level ports.
// ----------------------------------------------------------------------------
`ifndef LCG_RANGED_RANDOM_ASSERT_SVH
`define LCG_RANGED_RANDOM_ASSERT_SVH

// same-cycle implication
`define LRR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lrr_pkg.sv
// ----------------------------------------------------------------------------
// Ranged random generator package
// Widths, generator constants, command codes, states and cell control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(WORD_WIDTH);
   localparam int CMD_WIDTH   = 2;

   localparam logic [WORD_WIDTH-1:0]  LCG_MUL      = 32'd214013;
   localparam logic [WORD_WIDTH-1:0]  LCG_ADD      = 32'd2531011;
   localparam int                     TEMPER_SHIFT = 15;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LAST   = COUNT_WIDTH'(WORD_WIDTH - 1);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_RANGE_U = 2'd0,
      CMD_RANGE_S = 2'd1,
      CMD_RAW     = 2'd2,
      CMD_RESEED  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_LOAD,
      ST_DIVIDE,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/lrr_cell.sv
// ----------------------------------------------------------------------------
// Divider bit cell
// Holds one remainder bit and one dividend bit; subtracts one divisor bit
// with borrow ripple and shifts toward the upper neighbor on each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrr_cell
   import lrr_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          take,
   input  wire logic          dvd_load,
   input  wire logic          rem_left,
   input  wire logic          dvd_left,
   input  wire logic          span_bit,
   input  wire logic          borrow_left,
   output logic               rem_out,
   output logic               dvd_out,
   output logic               borrow_out
);

   logic rem_ff, rem_in;
   logic dvd_ff, dvd_in;
   logic diff;

   assign diff       = rem_left ^ span_bit ^ borrow_left;
   assign borrow_out = (~rem_left & span_bit) | (~(rem_left ^ span_bit) & borrow_left);

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (ctrl.load) begin
         rem_in = 1'b0;
         dvd_in = dvd_load;
      end else if (ctrl.step) begin
         rem_in = take ? diff : rem_left;
         dvd_in = dvd_left;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign rem_out = rem_ff;
   assign dvd_out = dvd_ff;

endmodule

`default_nettype wire

// File: sv/lrr_divider.sv
// ----------------------------------------------------------------------------
// Remainder chain
// Row of bit cells forming a restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrr_divider
   import lrr_pkg::*;
(
   input  wire logic                  clock,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [WORD_WIDTH-1:0] dividend,
   input  wire logic [WORD_WIDTH-1:0] divisor,
   output logic      [WORD_WIDTH-1:0] remainder
);

   logic [WORD_WIDTH-1:0] rem;
   logic [WORD_WIDTH-1:0] dvd;
   logic [WORD_WIDTH:0]   borrow;
   logic                  take;

   assign borrow[0] = 1'b0;
   // overflow bit set means the shifted remainder exceeds any divisor
   assign take      = rem[WORD_WIDTH-1] | ~borrow[WORD_WIDTH];

   for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_cell
      logic rem_left;
      logic dvd_left;
      if (i == 0) begin : g_first
         assign rem_left = dvd[WORD_WIDTH-1];
         assign dvd_left = 1'b0;
      end else begin : g_rest
         assign rem_left = rem[i-1];
         assign dvd_left = dvd[i-1];
      end
      lrr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .take        (take),
         .dvd_load    (dividend[i]),
         .rem_left    (rem_left),
         .dvd_left    (dvd_left),
         .span_bit    (divisor[i]),
         .borrow_left (borrow[i]),
         .rem_out     (rem[i]),
         .dvd_out     (dvd[i]),
         .borrow_out  (borrow[i+1])
      );
   end

   assign remainder = rem;

endmodule

`default_nettype wire

// File: sv/lcg_ranged_random.sv
// ----------------------------------------------------------------------------
// Ranged random generator
// 32-bit congruential generator with tempered output, ranged draws and reseed.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tdata carries range_low (bits 31:0) and range_high (63:32),
//   tuser the command. rsp channel: tdata the value, tuser bounds_inverted.
//   One response per request transaction.
//   Draws (ranged and raw) run from acceptance to rsp_tvalid in these steps:
//   advance the seed, load the remainder chain, 32 steps of the bit-cell
//   divider (one quotient bit per cycle), add the lower bound and register
//   the response once the output register is free. Reseed and inverted
//   bounds skip the divider and go straight to the response. The next
//   request is taken once the generator has returned to idle.
//   One request is in flight at a time; req_tready is high only when idle.
//   The response is held in an output register; while rsp_tready is low the
//   result stays there and a finished next request waits behind it.
//   Reset clears the seed to zero and drops any pending response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_ranged_random
   import lrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // range_low [31:0], range_high [63:32]
   input  wire logic [1:0]  req_tuser,   // cmd [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // value [31:0]
   output logic             rsp_tuser    // bounds_inverted [0]
);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   logic [WORD_WIDTH-1:0]  lo_ff, lo_in;
   logic [WORD_WIDTH-1:0]  hi_ff, hi_in;
   logic [WORD_WIDTH-1:0]  seed_ff, seed_in;
   logic [WORD_WIDTH-1:0]  span_ff, span_in;
   logic [WORD_WIDTH-1:0]  base_ff, base_in;
   logic [WORD_WIDTH-1:0]  pend_value_ff, pend_value_in;
   logic                   pend_flag_ff, pend_flag_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   logic [WORD_WIDTH-1:0] seed_adv;
   logic [WORD_WIDTH-1:0] tempered;
   logic [WORD_WIDTH-1:0] remainder;
   logic                  inverted;
   logic                  rsp_free;
   cell_ctrl_type         cell_ctrl;

   assign seed_adv = seed_ff * LCG_MUL + LCG_ADD;
   assign tempered = seed_ff ^ (seed_ff >> TEMPER_SHIFT);
   assign inverted = (cmd_ff == CMD_RANGE_S) ? ($signed(lo_ff) > $signed(hi_ff))
                                             : (lo_ff > hi_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   lrr_divider u_divider (
      .clock     (clock),
      .ctrl      (cell_ctrl),
      .dividend  (tempered),
      .divisor   (span_ff),
      .remainder (remainder)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      seed_in       = seed_ff;
      span_in       = span_ff;
      base_in       = base_ff;
      pend_value_in = pend_value_ff;
      pend_flag_in  = pend_flag_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_flag_in   = rsp_flag_ff;
      cell_ctrl     = '0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               lo_in    = req_tdata[WORD_WIDTH-1:0];
               hi_in    = req_tdata[2*WORD_WIDTH-1:WORD_WIDTH];
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            pend_flag_in = 1'b0;
            unique case (cmd_ff) inside
               CMD_RESEED: begin
                  seed_in       = lo_ff;
                  pend_value_in = '0;
                  state_in      = ST_DONE;
               end
               CMD_RAW: begin
                  // zero divisor leaves the tempered word as remainder
                  seed_in  = seed_adv;
                  base_in  = '0;
                  span_in  = '0;
                  state_in = ST_LOAD;
               end
               CMD_RANGE_U, CMD_RANGE_S: begin
                  if (inverted) begin
                     pend_value_in = hi_ff;
                     pend_flag_in  = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     seed_in  = seed_adv;
                     base_in  = lo_ff;
                     span_in  = hi_ff - lo_ff + 1'b1;
                     state_in = ST_LOAD;
                  end
               end
            endcase
         end
         ST_LOAD: begin
            cell_ctrl.load = 1'b1;
            count_in       = '0;
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cell_ctrl.step = 1'b1;
            count_in       = count_ff + 1'b1;
            if (count_ff == COUNT_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            pend_value_in = base_ff + remainder;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_flag_in  = pend_flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      span_ff       <= span_in;
      base_ff       <= base_in;
      pend_value_ff <= pend_value_in;
      pend_flag_ff  <= pend_flag_in;
      count_ff      <= count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_flag_ff;

endmodule

`default_nettype wire

// File: sv/lrr_checker.sv
// ----------------------------------------------------------------------------
// Ranged random generator checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lcg_ranged_random_assert.svh"

module lrr_checker
   import lrr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [WORD_WIDTH-1:0] rsp_tdata,
   input  wire logic                  rsp_tuser
);

   `LRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `LRR_ASSERT_SAME(a_reset_empty, clock, 1'b0, $past(reset), !rsp_tvalid, "response valid after reset")
   `LRR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "second request taken while busy")
   `LRR_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "response raised right after request")

endmodule

bind lcg_ranged_random lrr_checker u_lrr_checker (.*);

`default_nettype wire
